[rtl/ffsa_pkg.sv]
// ffsa_pkg: shared types, codes and defaults of the first-fit segment allocator
// no dependencies; imported by every other file of the block but ffsa_stream_if
package ffsa_pkg;

  localparam int unsigned POOL_BYTES_DEF   = 524288;
  localparam int unsigned HEADER_BYTES_DEF = 16;
  localparam int unsigned MAX_SEGMENTS_DEF = 64;

  localparam int FIELD_W  = 20;
  localparam int NEED_W   = FIELD_W + 1;  // rounding can carry out of the field
  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_SPACE = 2'd1,
    STATUS_BAD_PTR  = 2'd2
  } status_e;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [FIELD_W-1:0] req_size;
    logic [FIELD_W-1:0] addr;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  ptr_offset;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_RELEASE,
    OP_NULL
  } op_kind_e;

  typedef struct packed {
    op_kind_e           kind;
    logic [NEED_W-1:0]  need;
    logic [FIELD_W-1:0] addr;
  } op_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_SPLIT,
    S_TAKE,
    S_MERGE,
    S_FLUSH,
    S_DONE
  } back_state_e;

  function automatic logic [NEED_W-1:0] round8(input logic [FIELD_W-1:0] req);
    logic [NEED_W-1:0] sum;
    sum = {1'b0, req} + NEED_W'(7);
    return {sum[NEED_W-1:3], 3'b000};
  endfunction

endpackage

[rtl/ffsa_stream_if.sv]
// ffsa_stream_if: valid/ready channel with a typed payload
// depends on nothing; payload types come from ffsa_pkg at instantiation
interface ffsa_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/ffsa_ram.sv]
// ffsa_ram: generic simple dual-port ram, one write and one registered read
// depends on ffsa_pkg only through the common import convention
module ffsa_ram
  import ffsa_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/ffsa_front.sv]
// ffsa_front: accepts requests, rounds sizes, classifies them, two-entry op queue
// depends on ffsa_pkg and ffsa_stream_if
module ffsa_front
  import ffsa_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  ffsa_stream_if.sink   in_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output op_t           q_op_o
);

  op_t        fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  op_t        op_in;
  logic       push, pop;

  always_comb begin
    op_in.need = round8(in_i.data.req_size);
    op_in.addr = in_i.data.addr;
    if (in_i.data.cmd == CMD_RELEASE) begin
      op_in.kind = (in_i.data.addr == '0) ? OP_NULL : OP_RELEASE;
    end else begin
      op_in.kind = OP_ALLOC;
    end
  end

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_op_o     = fifo_q[rd_ptr_q];
  assign pop        = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= op_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

[rtl/ffsa_back.sv]
// ffsa_back: segment table in ram, first-fit scan, split shift, merge compaction
// depends on ffsa_pkg, ffsa_stream_if and ffsa_ram
module ffsa_back
  import ffsa_pkg::*;
#(
  parameter int unsigned POOL_BYTES   = POOL_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_ready_o,
  input  op_t           q_op_i,
  ffsa_stream_if.source out_o
);

  localparam int AW    = $clog2(POOL_BYTES);
  localparam int EW    = ((AW > NEED_W) ? AW : NEED_W) + 2;
  localparam int IW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW    = $clog2(MAX_SEGMENTS + 1);
  localparam int ENT_W = 2 * AW + 1;

  localparam logic [EW-1:0] HDR       = EW'(HEADER_BYTES);
  localparam logic [AW-1:0] INIT_SIZE = AW'(POOL_BYTES - HEADER_BYTES);
  localparam logic [CW-1:0] CNT_MAX   = CW'(MAX_SEGMENTS);

  back_state_e state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     rd_q, rd_d;
  logic [CW-1:0]     wr_q, wr_d;
  logic              dv_q, dv_d;
  logic [IW-1:0]     cidx_q, cidx_d;
  logic [ENT_W-1:0]  hit_q, hit_d;
  logic [IW-1:0]     hidx_q, hidx_d;
  logic              split_q, split_d;
  logic              pend_v_q, pend_v_d;
  logic [ENT_W-1:0]  pend_q, pend_d;
  op_t               op_q, op_d;
  logic [STATUS_W-1:0] res_st_q, res_st_d;
  logic [FIELD_W-1:0]  res_ptr_q, res_ptr_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              we;
  logic [IW-1:0]     waddr, raddr;
  logic [ENT_W-1:0]  wdata, rdata;

  logic [AW-1:0]     r_start, r_size, h_start, h_size, p_start, p_size;
  logic              r_free, p_free;
  logic [EW-1:0]     need_e;
  logic              fit, match, hit;
  logic [ENT_W-1:0]  ent_m;

  ffsa_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SEGMENTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign r_start = rdata[ENT_W-1 -: AW];
  assign r_size  = rdata[AW:1];
  assign h_start = hit_q[ENT_W-1 -: AW];
  assign h_size  = hit_q[AW:1];
  assign p_start = pend_q[ENT_W-1 -: AW];
  assign p_size  = pend_q[AW:1];
  assign p_free  = pend_q[0];
  // during compaction the released segment reads as free
  assign r_free  = rdata[0] || ((state_q == S_MERGE) && (cidx_q == hidx_q));
  assign ent_m   = {r_start, r_size, r_free};

  assign need_e = EW'(op_q.need);
  assign fit    = r_free && (EW'(r_size) >= need_e);
  assign match  = (EW'(r_start) + HDR) == EW'(op_q.addr);
  assign hit    = dv_q && ((op_q.kind == OP_ALLOC) ? fit : match);
  assign raddr  = rd_q[IW-1:0];

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    dv_d        = dv_q;
    cidx_d      = cidx_q;
    hit_d       = hit_q;
    hidx_d      = hidx_q;
    split_d     = split_q;
    pend_v_d    = pend_v_q;
    pend_d      = pend_q;
    op_d        = op_q;
    res_st_d    = res_st_q;
    res_ptr_d   = res_ptr_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    q_ready_o   = 1'b0;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;

    unique case (state_q)
      S_INIT: begin
        we      = 1'b1;
        wdata   = {AW'(0), INIT_SIZE, 1'b1};
        cnt_d   = CW'(1);
        state_d = S_IDLE;
      end

      S_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          op_d = q_op_i;
          rd_d = '0;
          dv_d = 1'b0;
          if (q_op_i.kind == OP_NULL) begin
            res_st_d  = STATUS_OK;
            res_ptr_d = '0;
            state_d   = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          hit_d  = rdata;
          hidx_d = cidx_q;
          dv_d   = 1'b0;
          if (op_q.kind == OP_ALLOC) begin
            split_d = (EW'(r_size) > need_e + HDR) && (cnt_q < CNT_MAX);
            rd_d    = cnt_q - CW'(1);
            state_d = ((EW'(r_size) > need_e + HDR) && (cnt_q < CNT_MAX)) ? S_SHIFT : S_TAKE;
          end else begin
            rd_d     = '0;
            wr_d     = '0;
            pend_v_d = 1'b0;
            state_d  = S_MERGE;
          end
        end else if (!dv_q && (rd_q == cnt_q)) begin
          res_st_d  = (op_q.kind == OP_ALLOC) ? STATUS_NO_SPACE : STATUS_BAD_PTR;
          res_ptr_d = '0;
          state_d   = S_DONE;
        end else if (rd_q < cnt_q) begin
          dv_d   = 1'b1;
          cidx_d = rd_q[IW-1:0];
          rd_d   = rd_q + CW'(1);
        end else begin
          dv_d = 1'b0;
        end
      end

      // move entries above the hit up by one, top first
      S_SHIFT: begin
        if (dv_q) begin
          we    = 1'b1;
          waddr = cidx_q + IW'(1);
          wdata = rdata;
        end
        if (rd_q != CW'(hidx_q)) begin
          dv_d   = 1'b1;
          cidx_d = rd_q[IW-1:0];
          rd_d   = rd_q - CW'(1);
        end else begin
          dv_d = 1'b0;
          if (!dv_q) state_d = S_SPLIT;
        end
      end

      S_SPLIT: begin
        we      = 1'b1;
        waddr   = hidx_q + IW'(1);
        wdata   = {AW'(EW'(h_start) + HDR + need_e),
                   AW'(EW'(h_size) - need_e - HDR), 1'b1};
        cnt_d   = cnt_q + CW'(1);
        state_d = S_TAKE;
      end

      S_TAKE: begin
        we        = 1'b1;
        waddr     = hidx_q;
        wdata     = {h_start, split_q ? AW'(op_q.need) : h_size, 1'b0};
        res_st_d  = STATUS_OK;
        res_ptr_d = FIELD_W'(EW'(h_start) + HDR);
        state_d   = S_DONE;
      end

      // one streaming pass: pairs of free neighbors collapse, read ahead of write
      S_MERGE: begin
        if (dv_q) begin
          if (!pend_v_q) begin
            pend_d   = ent_m;
            pend_v_d = 1'b1;
          end else if (p_free && r_free) begin
            we       = 1'b1;
            waddr    = wr_q[IW-1:0];
            wdata    = {p_start, AW'(EW'(p_size) + HDR + EW'(r_size)), 1'b1};
            wr_d     = wr_q + CW'(1);
            pend_v_d = 1'b0;
          end else begin
            we     = 1'b1;
            waddr  = wr_q[IW-1:0];
            wdata  = pend_q;
            wr_d   = wr_q + CW'(1);
            pend_d = ent_m;
          end
        end
        if (rd_q < cnt_q) begin
          dv_d   = 1'b1;
          cidx_d = rd_q[IW-1:0];
          rd_d   = rd_q + CW'(1);
        end else begin
          dv_d = 1'b0;
          if (!dv_q) state_d = S_FLUSH;
        end
      end

      S_FLUSH: begin
        if (pend_v_q) begin
          we    = 1'b1;
          waddr = wr_q[IW-1:0];
          wdata = pend_q;
        end
        cnt_d     = wr_q + CW'(pend_v_q);
        pend_v_d  = 1'b0;
        res_st_d  = STATUS_OK;
        res_ptr_d = '0;
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d      = 1'b1;
          out_d.status     = res_st_q;
          out_d.ptr_offset = res_ptr_q;
          state_d          = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= CW'(1);
      rd_q        <= '0;
      wr_q        <= '0;
      dv_q        <= 1'b0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      dv_q        <= dv_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cidx_q    <= cidx_d;
    hit_q     <= hit_d;
    hidx_q    <= hidx_d;
    split_q   <= split_d;
    pend_q    <= pend_d;
    op_q      <= op_d;
    res_st_q  <= res_st_d;
    res_ptr_q <= res_ptr_d;
    out_q     <= out_d;
  end

endmodule

[rtl/first_fit_segment_allocator_top.sv]
// first_fit_segment_allocator_top: request front end, op queue and table engine
// depends on ffsa_pkg, ffsa_stream_if, ffsa_front and ffsa_back
//
//   channel | dir | payload                       | transaction
//   in_i    | in  | cmd, req_size, addr           | valid && ready
//   out_o   | out | status, ptr_offset            | valid && ready
//
// one result per request; an allocate scans for the first fit and, when it splits,
// shifts the entries above the hit up by one; a release of a nonzero pointer scans
// and on a hit compacts the table, via the single read and write port of the table ram
// after reset the init state writes the initial free segment before the first request
// the front queue keeps taking requests, until its two entries are full, while a result waits on out_o
module first_fit_segment_allocator_top
  import ffsa_pkg::*;
#(
  parameter int unsigned POOL_BYTES   = POOL_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ffsa_stream_if.sink   in_i,
  ffsa_stream_if.source out_o
);

  logic q_valid, q_ready;
  op_t  q_op;

  ffsa_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_op_o    (q_op)
  );

  ffsa_back #(
    .POOL_BYTES   (POOL_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .q_op_i    (q_op),
    .out_o     (out_o)
  );

endmodule

[rtl/ffsa_checker.sv]
// ffsa_checker: port-level assertions of the allocator, bound to the top level
// depends on ffsa_pkg and first_fit_segment_allocator_top
module ffsa_checker
  import ffsa_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  logic [3:0] outstanding_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else begin
      outstanding_q <= outstanding_q + 4'(in_acc) - 4'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  a_fail_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status != STATUS_OK) |-> out_data_i.ptr_offset == '0)
    else $error("failed transaction carries a pointer");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> outstanding_q != '0)
    else $error("result without a pending request");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q <= 4'd4)
    else $error("too many requests in flight");

endmodule

bind first_fit_segment_allocator_top ffsa_checker u_ffsa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
